[rtl/core/qrp_pkg.sv]
package qrp_pkg;

  localparam int QW = 16;
  localparam int CW = 24;
  localparam int TW = 26;

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [CW-1:0] ctr_t;
  typedef logic signed [TW-1:0] shf_t;

  // Rotation part of the transform, row-major.
  typedef struct packed {
    q_t m00;
    q_t m01;
    q_t m02;
    q_t m10;
    q_t m11;
    q_t m12;
    q_t m20;
    q_t m21;
    q_t m22;
  } rot_t;

  typedef struct packed {
    ctr_t cx;
    ctr_t cy;
    ctr_t cz;
  } ctr3_t;

  function automatic q_t sat_q(input logic signed [33:0] v);
    q_t r;
    if (v > 34'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -34'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic shf_t sat_t(input logic signed [42:0] v);
    shf_t r;
    if (v > 43'sd33554431) begin
      r = 26'sh1ffffff;
    end else if (v < -43'sd33554432) begin
      r = 26'sh2000000;
    end else begin
      r = v[25:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/qrp_matrix.sv]
module qrp_matrix import qrp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  q_t    quat_x,
  input  q_t    quat_y,
  input  q_t    quat_z,
  input  q_t    quat_w,
  input  ctr3_t ctr_in,
  output logic  mat_valid,
  input  logic  mat_stall,
  output rot_t  rot,
  output ctr3_t ctr_out
);

  logic a_valid;
  logic a_ready;
  logic b_ready;

  logic signed [31:0] p_xx, p_yy, p_zz, p_ww;
  logic signed [31:0] p_xy, p_xz, p_yz, p_xw, p_yw, p_zw;
  ctr3_t a_ctr;

  assign b_ready  = !mat_valid || !mat_stall;
  assign a_ready  = !a_valid || b_ready;
  assign in_stall = !a_ready;

  // Stage A: the ten component products, exact Q4.28.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      p_xx  <= quat_x * quat_x;
      p_yy  <= quat_y * quat_y;
      p_zz  <= quat_z * quat_z;
      p_ww  <= quat_w * quat_w;
      p_xy  <= quat_x * quat_y;
      p_xz  <= quat_x * quat_z;
      p_yz  <= quat_y * quat_z;
      p_xw  <= quat_x * quat_w;
      p_yw  <= quat_y * quat_w;
      p_zw  <= quat_z * quat_w;
      a_ctr <= ctr_in;
    end
  end

  // Stage B: exact sums, rounded and saturated to Q2.14. Entries with the
  // factor two drop one bit less.
  logic signed [33:0] s00, s11, s22, s01, s02, s10, s12, s20, s21;
  rot_t rot_next;

  always_comb begin
    s00 = 34'(p_xx) - 34'(p_yy) - 34'(p_zz) + 34'(p_ww);
    s11 = 34'(p_yy) - 34'(p_xx) - 34'(p_zz) + 34'(p_ww);
    s22 = 34'(p_zz) - 34'(p_xx) - 34'(p_yy) + 34'(p_ww);
    s01 = 34'(p_xy) + 34'(p_zw);
    s02 = 34'(p_xz) - 34'(p_yw);
    s10 = 34'(p_xy) - 34'(p_zw);
    s12 = 34'(p_yz) + 34'(p_xw);
    s20 = 34'(p_xz) + 34'(p_yw);
    s21 = 34'(p_yz) - 34'(p_xw);
    rot_next.m00 = sat_q((s00 + 34'sd8192) >>> 14);
    rot_next.m11 = sat_q((s11 + 34'sd8192) >>> 14);
    rot_next.m22 = sat_q((s22 + 34'sd8192) >>> 14);
    rot_next.m01 = sat_q((s01 + 34'sd4096) >>> 13);
    rot_next.m02 = sat_q((s02 + 34'sd4096) >>> 13);
    rot_next.m10 = sat_q((s10 + 34'sd4096) >>> 13);
    rot_next.m12 = sat_q((s12 + 34'sd4096) >>> 13);
    rot_next.m20 = sat_q((s20 + 34'sd4096) >>> 13);
    rot_next.m21 = sat_q((s21 + 34'sd4096) >>> 13);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mat_valid <= 1'b0;
    end else if (b_ready) begin
      mat_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      rot     <= rot_next;
      ctr_out <= a_ctr;
    end
  end

endmodule

[rtl/core/quat_rotation_about_point_top.sv]
// Turns a quaternion (Q2.14, not normalized, so the matrix carries |q|^2) and
// a center point (8 fraction bits) into the 3x3 rotation of a transform plus
// the translation c - R*c, so that the transform rotates about the center.
// The block takes one beat per cycle while in_stall is low, and each result
// leaves through the output register of the last stage. The four register
// stages are component products, matrix sums with rounding and saturation,
// matrix-by-center products, then the translation sums into the output
// register. Each stage holds its beat while the one after it is stalled, so
// in_stall follows out_stall through the pipeline only when every stage is full.
module quat_rotation_about_point_top import qrp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  q_t   quat_x,
  input  q_t   quat_y,
  input  q_t   quat_z,
  input  q_t   quat_w,
  input  ctr_t center_x,
  input  ctr_t center_y,
  input  ctr_t center_z,
  output logic out_valid,
  input  logic out_stall,
  output q_t   m00,
  output q_t   m01,
  output q_t   m02,
  output q_t   m10,
  output q_t   m11,
  output q_t   m12,
  output q_t   m20,
  output q_t   m21,
  output q_t   m22,
  output shf_t shift_x,
  output shf_t shift_y,
  output shf_t shift_z
);

  ctr3_t ctr_in;
  ctr3_t b_ctr;
  rot_t  b_rot;
  logic  b_valid;
  logic  b_stall;

  assign ctr_in.cx = center_x;
  assign ctr_in.cy = center_y;
  assign ctr_in.cz = center_z;

  qrp_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .quat_w    (quat_w),
    .ctr_in    (ctr_in),
    .mat_valid (b_valid),
    .mat_stall (b_stall),
    .rot       (b_rot),
    .ctr_out   (b_ctr)
  );

  logic c_valid;
  logic c_ready;
  logic d_ready;

  assign d_ready = !out_valid || !out_stall;
  assign c_ready = !c_valid || d_ready;
  assign b_stall = !c_ready;

  // Stage C: matrix entries times center coordinates, 22 fraction bits.
  logic signed [39:0] pr00, pr01, pr02, pr10, pr11, pr12, pr20, pr21, pr22;
  ctr3_t c_ctr;
  rot_t  c_rot;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_valid) begin
      pr00  <= b_rot.m00 * b_ctr.cx;
      pr01  <= b_rot.m01 * b_ctr.cy;
      pr02  <= b_rot.m02 * b_ctr.cz;
      pr10  <= b_rot.m10 * b_ctr.cx;
      pr11  <= b_rot.m11 * b_ctr.cy;
      pr12  <= b_rot.m12 * b_ctr.cz;
      pr20  <= b_rot.m20 * b_ctr.cx;
      pr21  <= b_rot.m21 * b_ctr.cy;
      pr22  <= b_rot.m22 * b_ctr.cz;
      c_ctr <= b_ctr;
      c_rot <= b_rot;
    end
  end

  // Stage D: center scaled to 22 fraction bits minus the row dot product,
  // rounded back to 8 fraction bits and saturated.
  logic signed [42:0] acc_x, acc_y, acc_z;

  always_comb begin
    acc_x = (43'(c_ctr.cx) <<< 14) - (43'(pr00) + 43'(pr01) + 43'(pr02));
    acc_y = (43'(c_ctr.cy) <<< 14) - (43'(pr10) + 43'(pr11) + 43'(pr12));
    acc_z = (43'(c_ctr.cz) <<< 14) - (43'(pr20) + 43'(pr21) + 43'(pr22));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (d_ready) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && c_valid) begin
      m00     <= c_rot.m00;
      m01     <= c_rot.m01;
      m02     <= c_rot.m02;
      m10     <= c_rot.m10;
      m11     <= c_rot.m11;
      m12     <= c_rot.m12;
      m20     <= c_rot.m20;
      m21     <= c_rot.m21;
      m22     <= c_rot.m22;
      shift_x <= sat_t((acc_x + 43'sd8192) >>> 14);
      shift_y <= sat_t((acc_y + 43'sd8192) >>> 14);
      shift_z <= sat_t((acc_z + 43'sd8192) >>> 14);
    end
  end

endmodule
